/* src/bole_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Shared widths, action codes and sequencer states.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int DATA_W      = 32;
  localparam int ACT_W       = 3;
  localparam int POS_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_ORD   = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REM_BACK  = 3'd4,
    ACT_REM_VAL   = 3'd5,
    ACT_READ      = 3'd6,
    ACT_FIND      = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHUP,
    ST_SHDN,
    ST_WRITE,
    ST_READ,
    ST_FIN
  } state_t;

endpackage

/* src/bole_ram.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine entry memory
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module bole_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wr_addr,
  input  logic [bole_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [bole_pkg::DATA_W-1:0] rd_data
);

  logic [bole_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/bounded_ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of up to DEPTH signed values kept in one entry memory.
// ----------------------------------------------------------------------------
// Each request is handled on its own by a sequencer around the entry memory,
// which moves one entry per cycle through its single read and write port.
// Inserting at the back, removing at the back and reading a position need
// no scan or shift; inserting or removing at the front, ordered inserts,
// removals by value and finds grow with the list, since entries ahead of
// the insertion or removal point are scanned and those after it shifted.
// A new request is taken as soon as the previous result has been placed in
// the output register, even while that result still waits for its transfer.
module bounded_ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // item_value [31:0], position [36:32], zero fill above
  input  logic [bole_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action [2:0]
  input  logic [bole_pkg::ACT_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ok [0], read_value [32:1], found_position [37:33], entry_count [42:38],
  // zero fill above
  output logic [bole_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PCW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;
  localparam int DW  = bole_pkg::DATA_W;
  localparam int PW  = bole_pkg::POS_W;

  bole_pkg::state_t state_r, state_nxt;
  bole_pkg::act_t   act_r, act_nxt;
  logic signed [DW-1:0] val_r, val_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  at_r, at_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           ok_r, ok_nxt;
  logic [DW-1:0]  rdv_r, rdv_nxt;
  logic [PW-1:0]  fp_r, fp_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [bole_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic           we;
  logic [AW-1:0]  wr_addr;
  logic [DW-1:0]  wr_data;
  logic [AW-1:0]  rd_addr;
  logic [DW-1:0]  rd_data;

  logic           full, empty, hit, last, pos_ok;
  logic [CW-1:0]  ptr_ext, ptr_inc, cnt_dec;
  logic [PCW-1:0] pos_ext, pos_dec, ptr_inc_w;
  logic signed [DW-1:0] entry;
  logic [DW-1:0]  in_value;
  logic [PW-1:0]  in_pos;

  bole_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_value   = in_tdata[DW-1:0];
  assign in_pos     = in_tdata[DW+PW-1:DW];
  assign in_tready  = (state_r == bole_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign ptr_ext   = CW'(ptr_r);
  assign ptr_inc   = ptr_ext + CW'(1);
  assign ptr_inc_w = PCW'(ptr_inc);
  assign cnt_dec   = count_r - CW'(1);
  assign last      = (ptr_inc == count_r);
  assign pos_ext   = PCW'(in_pos);
  assign pos_dec   = pos_ext - PCW'(1);
  assign pos_ok    = (in_pos != '0) && (pos_ext <= PCW'(count_r));
  assign entry     = $signed(rd_data);

  always_comb begin
    if (act_r == bole_pkg::ACT_INS_ORD) begin
      hit = (ptr_r == '0) ? (entry > val_r) : (entry >= val_r);
    end else begin
      hit = (entry == val_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    at_nxt        = at_r;
    count_nxt     = count_r;
    ok_nxt        = ok_r;
    rdv_nxt       = rdv_r;
    fp_nxt        = fp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data;
    rd_addr       = ptr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bole_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = bole_pkg::act_t'(in_tuser);
          val_nxt   = $signed(in_value);
          ok_nxt    = 1'b0;
          rdv_nxt   = '0;
          fp_nxt    = '0;
          state_nxt = bole_pkg::ST_FIN;
          unique case (bole_pkg::act_t'(in_tuser))
            bole_pkg::ACT_INS_FRONT: begin
              at_nxt = '0;
              if (!full) begin
                if (empty) begin
                  state_nxt = bole_pkg::ST_WRITE;
                end else begin
                  rd_addr   = cnt_dec[AW-1:0];
                  ptr_nxt   = cnt_dec[AW-1:0];
                  state_nxt = bole_pkg::ST_SHUP;
                end
              end
            end
            bole_pkg::ACT_INS_BACK: begin
              at_nxt = count_r;
              if (!full) begin
                state_nxt = bole_pkg::ST_WRITE;
              end
            end
            bole_pkg::ACT_INS_ORD: begin
              at_nxt = '0;
              if (!full) begin
                if (empty) begin
                  state_nxt = bole_pkg::ST_WRITE;
                end else begin
                  rd_addr   = '0;
                  ptr_nxt   = '0;
                  state_nxt = bole_pkg::ST_SCAN;
                end
              end
            end
            bole_pkg::ACT_REM_FRONT: begin
              if (!empty) begin
                ok_nxt = 1'b1;
                if (count_r == CW'(1)) begin
                  count_nxt = cnt_dec;
                end else begin
                  rd_addr   = AW'(1);
                  ptr_nxt   = AW'(1);
                  state_nxt = bole_pkg::ST_SHDN;
                end
              end
            end
            bole_pkg::ACT_REM_BACK: begin
              if (!empty) begin
                ok_nxt    = 1'b1;
                count_nxt = cnt_dec;
              end
            end
            bole_pkg::ACT_REM_VAL,
            bole_pkg::ACT_FIND: begin
              if (!empty) begin
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = bole_pkg::ST_SCAN;
              end
            end
            bole_pkg::ACT_READ: begin
              if (pos_ok) begin
                rd_addr   = pos_dec[AW-1:0];
                state_nxt = bole_pkg::ST_READ;
              end
            end
            default: begin
              state_nxt = bole_pkg::ST_FIN;
            end
          endcase
        end
      end

      bole_pkg::ST_SCAN: begin
        if (hit) begin
          priority case (act_r)
            bole_pkg::ACT_INS_ORD: begin
              at_nxt    = ptr_ext;
              rd_addr   = cnt_dec[AW-1:0];
              ptr_nxt   = cnt_dec[AW-1:0];
              state_nxt = bole_pkg::ST_SHUP;
            end
            bole_pkg::ACT_REM_VAL: begin
              ok_nxt = 1'b1;
              if (last) begin
                count_nxt = cnt_dec;
                state_nxt = bole_pkg::ST_FIN;
              end else begin
                rd_addr   = ptr_inc[AW-1:0];
                ptr_nxt   = ptr_inc[AW-1:0];
                state_nxt = bole_pkg::ST_SHDN;
              end
            end
            default: begin
              ok_nxt    = 1'b1;
              fp_nxt    = ptr_inc_w[PW-1:0];
              state_nxt = bole_pkg::ST_FIN;
            end
          endcase
        end else if (last) begin
          if (act_r == bole_pkg::ACT_INS_ORD) begin
            at_nxt    = count_r;
            state_nxt = bole_pkg::ST_WRITE;
          end else begin
            state_nxt = bole_pkg::ST_FIN;
          end
        end else begin
          rd_addr = ptr_inc[AW-1:0];
          ptr_nxt = ptr_inc[AW-1:0];
        end
      end

      bole_pkg::ST_SHUP: begin
        we      = 1'b1;
        wr_addr = ptr_inc[AW-1:0];
        wr_data = rd_data;
        if (ptr_ext == at_r) begin
          state_nxt = bole_pkg::ST_WRITE;
        end else begin
          rd_addr = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end

      bole_pkg::ST_SHDN: begin
        we      = 1'b1;
        wr_addr = ptr_r - AW'(1);
        wr_data = rd_data;
        if (last) begin
          count_nxt = cnt_dec;
          state_nxt = bole_pkg::ST_FIN;
        end else begin
          rd_addr = ptr_inc[AW-1:0];
          ptr_nxt = ptr_inc[AW-1:0];
        end
      end

      bole_pkg::ST_WRITE: begin
        we        = 1'b1;
        wr_addr   = at_r[AW-1:0];
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
        ok_nxt    = 1'b1;
        state_nxt = bole_pkg::ST_FIN;
      end

      bole_pkg::ST_READ: begin
        rdv_nxt   = rd_data;
        ok_nxt    = 1'b1;
        state_nxt = bole_pkg::ST_FIN;
      end

      bole_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(bole_pkg::OUT_TDATA_W-DW-2*PW-1){1'b0}},
                           PW'(count_r), fp_r, rdv_r, ok_r};
          state_nxt     = bole_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bole_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bole_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    at_r       <= at_nxt;
    ok_r       <= ok_nxt;
    rdv_r      <= rdv_nxt;
    fp_r       <= fp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
